// ===== hdl/svpa_pkg.sv =====
package svpa_pkg;

   localparam logic [1:0] KIND_NOTE_ON  = 2'd0;
   localparam logic [1:0] KIND_NOTE_OFF = 2'd1;
   localparam logic [1:0] KIND_PROGRESS = 2'd2;
   localparam logic [1:0] KIND_FINISH   = 2'd3;

   localparam logic [2:0] STAT_NONE    = 3'd0;
   localparam logic [2:0] STAT_STARTED = 3'd1;
   localparam logic [2:0] STAT_BLOCKED = 3'd2;
   localparam logic [2:0] STAT_STEAL   = 3'd3;
   localparam logic [2:0] STAT_ABORTED = 3'd4;
   localparam logic [2:0] STAT_REQUEUE = 3'd5;

   localparam logic [1:0] SMP_EMPTY    = 2'd1;
   localparam logic [1:0] SMP_NULL_LEN = 2'd2;

   localparam logic [1:0] RTG_RESTART  = 2'd0;
   localparam logic [1:0] RTG_NOTE_OFF = 2'd1;
   localparam logic [1:0] RTG_NONE     = 2'd2;

   localparam logic [6:0] FULL_VOLUME = 7'd127;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  voice_id;
      logic [6:0]  note_number;
      logic [6:0]  velocity;
      logic [5:0]  slot_index;
      logic [31:0] play_position;
      logic [1:0]  sample_status;
      logic [3:0]  sample_priority;
      logic [1:0]  retrig_sel;
      logic [3:0]  choke_grp;
      logic [2:0]  sample_flags;
   } item_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [5:0]  target_slot;
      logic [6:0]  start_volume;
      logic [63:0] fade_mask;
      logic [7:0]  out_voice;
      logic [6:0]  out_note;
      logic [6:0]  out_velocity;
   } rsp_type;

endpackage

// ===== hdl/sampler_voice_allocator.sv =====
// Voice allocator for a sample player.
// Request channel (req_*): one beat per event. tuser carries the event kind
// (note on, note off, progress, finished); tdata carries the note and the
// looked-up sample attributes. Response channel (rsp_*): exactly one beat
// per request, in request order, with the status in tuser.
// A front stage classifies events (zero-velocity note on becomes note off)
// into a two-beat queue; a back-end sequencer walks the slot table one
// slot per cycle through a registered read of the slot memories.
// A note on runs a retrigger scan that stops at the first match, then,
// unless the retrigger mode aborts it, a choke-group / free-slot / steal
// scan; a note off runs one scan; progress, finished and empty-sample note
// on skip the scan. One event is in the back end at a time; the slot scan
// sets the rate.
// Reset clears the slot busy/fading/stolen flags, the queue and the output;
// the slot memories need no clearing pass.
// While rsp_tready is low the response holds, the back end waits with its
// result, and the queue keeps taking requests until it is full.
module sampler_voice_allocator import svpa_pkg::*; #(
   parameter int NUM_SLOTS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // voice_id, note_number, velocity, slot_index, play_position,
   // sample_status, sample_priority, retrig_sel, choke_grp, sample_flags
   input  logic [79:0]  req_tdata,
   // kind
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // target_slot, start_volume, fade_mask, out_voice, out_note, out_velocity
   output logic [103:0] rsp_tdata,
   // status
   output logic [2:0]   rsp_tuser
);

   logic     q_valid, q_pop;
   item_type q_item;
   rsp_type  rsp;

   svpa_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_valid    (q_valid),
      .q_pop      (q_pop),
      .q_item     (q_item)
   );

   svpa_engine #(.NUM_SLOTS(NUM_SLOTS)) u_engine (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .q_item    (q_item),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_rsp   (rsp)
   );

   assign rsp_tuser = rsp.status;
   assign rsp_tdata = {5'd0, rsp.out_velocity, rsp.out_note, rsp.out_voice,
                       rsp.fade_mask, rsp.start_volume, rsp.target_slot};

endmodule

// ===== hdl/svpa_front.sv =====
module svpa_front import svpa_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,
   input  logic [1:0]  req_tuser,
   output logic        q_valid,
   input  logic        q_pop,
   output item_type    q_item
);

   item_type   q_ff [2];
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] count_ff, count_in;
   item_type   cls;
   logic       push;

   // unpack and classify: a note on with zero velocity is a note off
   always_comb begin
      cls.voice_id        = req_tdata[7:0];
      cls.note_number     = req_tdata[14:8];
      cls.velocity        = req_tdata[21:15];
      cls.slot_index      = req_tdata[27:22];
      cls.play_position   = req_tdata[59:28];
      cls.sample_status   = req_tdata[61:60];
      cls.sample_priority = req_tdata[65:62];
      cls.retrig_sel      = req_tdata[67:66];
      cls.choke_grp       = req_tdata[71:68];
      cls.sample_flags    = req_tdata[74:72];
      cls.kind            = req_tuser;
      if (req_tuser == KIND_NOTE_ON && req_tdata[21:15] == 7'd0) begin
         cls.kind = KIND_NOTE_OFF;
      end
   end

   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (count_ff != 2'd0);
   assign q_item     = q_ff[rptr_ff];

   always_comb begin
      wptr_in  = wptr_ff ^ push;
      rptr_in  = rptr_ff ^ (q_pop && q_valid);
      count_in = count_ff + 2'(push) - 2'(q_pop && q_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wptr_ff] <= cls;
      end
   end

endmodule

// ===== hdl/svpa_engine.sv =====
module svpa_engine import svpa_pkg::*; #(
   parameter int NUM_SLOTS = 16
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     q_valid,
   output logic     q_pop,
   input  item_type q_item,
   output logic     out_valid,
   input  logic     out_ready,
   output rsp_type  out_rsp
);

   localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CNT_W = $clog2(NUM_SLOTS + 1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SETUP = 3'd1;
   localparam logic [2:0] ST_SCAN1 = 3'd2;
   localparam logic [2:0] ST_SCAN2 = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   logic [2:0]           state_ff, state_in;
   item_type             cur_ff, cur_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 ev_valid_ff, ev_valid_in;
   logic [IDX_W-1:0]     ev_idx_ff, ev_idx_in;
   logic [NUM_SLOTS-1:0] busy_ff, busy_in;
   logic [NUM_SLOTS-1:0] fading_ff, fading_in;
   logic [NUM_SLOTS-1:0] stolen_ff, stolen_in;
   logic [63:0]          mask_ff, mask_in;
   logic                 abort_ff, abort_in;
   logic                 found_ff, found_in;
   logic [IDX_W-1:0]     free_idx_ff, free_idx_in;
   logic                 cand_v_ff, cand_v_in;
   logic [IDX_W-1:0]     cand_idx_ff, cand_idx_in;
   logic [3:0]           cand_prio_ff, cand_prio_in;
   logic [31:0]          cand_pos_ff, cand_pos_in;
   logic                 out_valid_ff, out_valid_in;
   rsp_type              out_ff, out_in;

   logic [14:0] vn_mem   [NUM_SLOTS];
   logic [13:0] attr_mem [NUM_SLOTS];
   logic [31:0] pos_mem  [NUM_SLOTS];
   logic [21:0] park_mem [NUM_SLOTS];
   logic [14:0] rd_vn_ff;
   logic [13:0] rd_attr_ff;
   logic [31:0] rd_pos_ff;
   logic [21:0] rd_park_ff;

   logic [IDX_W-1:0] rd_addr;
   logic             vn_we, attr_we, pos_we, park_we;
   logic [IDX_W-1:0] wr_idx, pos_wa;
   logic [31:0]      pos_wd;
   logic             fade_en;
   logic [IDX_W-1:0] fade_idx;

   logic [14:0]      cur_vn;
   logic [IDX_W-1:0] sidx;
   logic             sidx_ok;
   logic             ev_busy, ev_fad, ev_stl, ev_last, go;
   logic [3:0]       rd_prio, rd_group;
   logic [1:0]       rd_rmode;
   logic [2:0]       rd_flags;

   assign cur_vn   = {cur_ff.voice_id, cur_ff.note_number};
   assign sidx     = cur_ff.slot_index[IDX_W-1:0];
   assign sidx_ok  = ({1'b0, cur_ff.slot_index} < 7'(NUM_SLOTS));
   assign ev_busy  = busy_ff[ev_idx_ff];
   assign ev_fad   = fading_ff[ev_idx_ff];
   assign ev_stl   = stolen_ff[ev_idx_ff];
   assign ev_last  = (ev_idx_ff == IDX_W'(NUM_SLOTS - 1));
   assign rd_prio  = rd_attr_ff[3:0];
   assign rd_rmode = rd_attr_ff[5:4];
   assign rd_group = rd_attr_ff[9:6];
   assign rd_flags = rd_attr_ff[12:10];
   assign go       = (state_ff == ST_DONE) && (!out_valid_ff || out_ready);
   assign q_pop    = (state_ff == ST_IDLE) && q_valid;
   assign out_valid = out_valid_ff;
   assign out_rsp   = out_ff;

   always_comb begin
      if (state_ff == ST_SCAN1 || state_ff == ST_SCAN2) begin
         rd_addr = cnt_ff[IDX_W-1:0];
      end else begin
         rd_addr = sidx;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      cnt_in       = cnt_ff;
      ev_valid_in  = 1'b0;
      ev_idx_in    = ev_idx_ff;
      busy_in      = busy_ff;
      stolen_in    = stolen_ff;
      abort_in     = abort_ff;
      found_in     = found_ff;
      free_idx_in  = free_idx_ff;
      cand_v_in    = cand_v_ff;
      cand_idx_in  = cand_idx_ff;
      cand_prio_in = cand_prio_ff;
      cand_pos_in  = cand_pos_ff;
      out_valid_in = out_valid_ff && !out_ready;
      out_in       = out_ff;
      vn_we        = 1'b0;
      attr_we      = 1'b0;
      pos_we       = 1'b0;
      park_we      = 1'b0;
      wr_idx       = free_idx_ff;
      pos_wa       = free_idx_ff;
      pos_wd       = 32'd0;
      fade_en      = 1'b0;
      fade_idx     = ev_idx_ff;

      // issue stage of the slot scan
      if ((state_ff == ST_SCAN1 || state_ff == ST_SCAN2) &&
          (cnt_ff < CNT_W'(NUM_SLOTS))) begin
         cnt_in      = cnt_ff + CNT_W'(1);
         ev_valid_in = 1'b1;
         ev_idx_in   = cnt_ff[IDX_W-1:0];
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               cur_in   = q_item;
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            cnt_in    = '0;
            abort_in  = 1'b0;
            found_in  = 1'b0;
            cand_v_in = 1'b0;
            if (cur_ff.kind == KIND_NOTE_ON && cur_ff.sample_status == SMP_EMPTY) begin
               abort_in = 1'b1;
               state_in = ST_DONE;
            end else if (cur_ff.kind == KIND_NOTE_ON || cur_ff.kind == KIND_NOTE_OFF) begin
               state_in = ST_SCAN1;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_SCAN1: begin
            if (ev_valid_ff) begin
               if (cur_ff.kind == KIND_NOTE_OFF) begin
                  if (ev_busy && rd_vn_ff == cur_vn && rd_flags[1]) begin
                     fade_en = 1'b1;
                  end
                  if (ev_last) begin
                     state_in = ST_DONE;
                  end
               end else if (ev_busy && !ev_fad && rd_vn_ff == cur_vn) begin
                  // first live slot with the same voice and note
                  cnt_in      = '0;
                  ev_valid_in = 1'b0;
                  state_in    = ST_SCAN2;
                  case (rd_rmode)
                     RTG_RESTART: fade_en = 1'b1;
                     RTG_NOTE_OFF: begin
                        fade_en  = 1'b1;
                        abort_in = 1'b1;
                        state_in = ST_DONE;
                     end
                     RTG_NONE: begin
                        abort_in = 1'b1;
                        state_in = ST_DONE;
                     end
                     default: ;
                  endcase
               end else if (ev_last) begin
                  cnt_in      = '0;
                  ev_valid_in = 1'b0;
                  state_in    = ST_SCAN2;
               end
            end
         end
         ST_SCAN2: begin
            if (ev_valid_ff) begin
               if (ev_busy && cur_ff.choke_grp != 4'd0 && rd_group == cur_ff.choke_grp) begin
                  fade_en = 1'b1;
               end
               if (!ev_busy && !found_ff) begin
                  found_in    = 1'b1;
                  free_idx_in = ev_idx_ff;
               end
               if (ev_busy && !ev_stl && !rd_flags[0] && rd_prio <= cur_ff.sample_priority &&
                   (!cand_v_ff || rd_prio < cand_prio_ff ||
                    (rd_prio == cand_prio_ff && rd_pos_ff > cand_pos_ff))) begin
                  cand_v_in    = 1'b1;
                  cand_idx_in  = ev_idx_ff;
                  cand_prio_in = rd_prio;
                  cand_pos_in  = rd_pos_ff;
               end
               if (ev_last) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (go) begin
               out_in       = '0;
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
               case (cur_ff.kind)
                  KIND_NOTE_ON: begin
                     if (abort_ff) begin
                        out_in.status = STAT_ABORTED;
                     end else if (found_ff) begin
                        out_in.target_slot = 6'(free_idx_ff);
                        if (cur_ff.sample_status != SMP_NULL_LEN) begin
                           busy_in[free_idx_ff]   = 1'b1;
                           stolen_in[free_idx_ff] = 1'b0;
                           vn_we   = 1'b1;
                           attr_we = 1'b1;
                           pos_we  = 1'b1;
                           out_in.status       = STAT_STARTED;
                           out_in.start_volume = cur_ff.sample_flags[2] ? FULL_VOLUME
                                                                        : cur_ff.velocity;
                        end
                     end else if (cand_v_ff) begin
                        wr_idx   = cand_idx_ff;
                        park_we  = 1'b1;
                        fade_en  = 1'b1;
                        fade_idx = cand_idx_ff;
                        stolen_in[cand_idx_ff] = 1'b1;
                        out_in.status      = STAT_STEAL;
                        out_in.target_slot = 6'(cand_idx_ff);
                     end else begin
                        out_in.status = STAT_BLOCKED;
                     end
                  end
                  KIND_PROGRESS: begin
                     if (sidx_ok && busy_ff[sidx]) begin
                        pos_we = 1'b1;
                        pos_wa = sidx;
                        pos_wd = cur_ff.play_position;
                     end
                  end
                  KIND_FINISH: begin
                     if (sidx_ok && busy_ff[sidx]) begin
                        busy_in[sidx] = 1'b0;
                        pos_we = 1'b1;
                        pos_wa = sidx;
                        out_in.target_slot = cur_ff.slot_index;
                        if (stolen_ff[sidx]) begin
                           stolen_in[sidx]     = 1'b0;
                           out_in.status       = STAT_REQUEUE;
                           out_in.out_voice    = rd_park_ff[21:14];
                           out_in.out_note     = rd_park_ff[13:7];
                           out_in.out_velocity = rd_park_ff[6:0];
                        end
                     end
                  end
                  default: ;
               endcase
               out_in.fade_mask = mask_in;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // fade port: flag the slot, note it in the mask if newly fading
   always_comb begin
      fading_in = fading_ff;
      mask_in   = (state_ff == ST_SETUP) ? 64'd0 : mask_ff;
      if (fade_en) begin
         mask_in = mask_in | (64'(!fading_ff[fade_idx]) << fade_idx);
         fading_in[fade_idx] = 1'b1;
      end
      if (go && cur_ff.kind == KIND_NOTE_ON && !abort_ff && found_ff &&
          cur_ff.sample_status != SMP_NULL_LEN) begin
         fading_in[free_idx_ff] = 1'b0;
      end
      if (go && cur_ff.kind == KIND_FINISH && sidx_ok && busy_ff[sidx]) begin
         fading_in[sidx] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ev_valid_ff  <= 1'b0;
         busy_ff      <= '0;
         fading_ff    <= '0;
         stolen_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ev_valid_ff  <= ev_valid_in;
         busy_ff      <= busy_in;
         fading_ff    <= fading_in;
         stolen_ff    <= stolen_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      cnt_ff       <= cnt_in;
      ev_idx_ff    <= ev_idx_in;
      mask_ff      <= mask_in;
      abort_ff     <= abort_in;
      found_ff     <= found_in;
      free_idx_ff  <= free_idx_in;
      cand_v_ff    <= cand_v_in;
      cand_idx_ff  <= cand_idx_in;
      cand_prio_ff <= cand_prio_in;
      cand_pos_ff  <= cand_pos_in;
      out_ff       <= out_in;
   end

   always_ff @(posedge clock) begin
      if (vn_we) begin
         vn_mem[wr_idx] <= cur_vn;
      end
      if (attr_we) begin
         attr_mem[wr_idx] <= {1'b0, cur_ff.sample_flags, cur_ff.choke_grp,
                              cur_ff.retrig_sel, cur_ff.sample_priority};
      end
      if (pos_we) begin
         pos_mem[pos_wa] <= pos_wd;
      end
      if (park_we) begin
         park_mem[wr_idx] <= {cur_ff.voice_id, cur_ff.note_number, cur_ff.velocity};
      end
      rd_vn_ff   <= vn_mem[rd_addr];
      rd_attr_ff <= attr_mem[rd_addr];
      rd_pos_ff  <= pos_mem[rd_addr];
      rd_park_ff <= park_mem[rd_addr];
   end

endmodule

// ===== hdl/svpa_checker.sv =====
module svpa_checker import svpa_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [103:0] rsp_tdata,
   input logic [2:0]   rsp_tuser
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   a_reset: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser <= STAT_REQUEUE)
      else $error("bad status code");

   a_volume: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tuser == STAT_STARTED) == (rsp_tdata[12:6] != 7'd0)))
      else $error("start volume does not match started status");

endmodule

bind sampler_voice_allocator svpa_checker u_svpa_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ===== tb/tb_top.sv =====
module tb_top;
   import svpa_pkg::*;

   localparam int NSLOT = 16;
   localparam int N_RANDOM = 360;
   localparam int DRAIN_CYCLES = 4 * NSLOT + 20;
   localparam int ITEM_W = $bits(item_type);

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   // voice_id, note_number, velocity, slot_index, play_position,
   // sample_status, sample_priority, retrig_sel, choke_grp, sample_flags
   logic [79:0]  req_tdata = '0;
   // kind
   logic [1:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   // target_slot, start_volume, fade_mask, out_voice, out_note, out_velocity
   logic [103:0] rsp_tdata;
   // status
   logic [2:0]   rsp_tuser;

   sampler_voice_allocator #(.NUM_SLOTS(NSLOT)) dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor copy of the slot table
   logic        busy [NSLOT];
   logic        fading [NSLOT];
   logic        stolen [NSLOT];
   logic [7:0]  s_voice [NSLOT];
   logic [6:0]  s_note [NSLOT];
   logic [3:0]  s_prio [NSLOT];
   logic [1:0]  s_rtg [NSLOT];
   logic [3:0]  s_group [NSLOT];
   logic [2:0]  s_flags [NSLOT];
   logic [31:0] s_pos [NSLOT];
   logic [21:0] s_parked [NSLOT];

   rsp_type expected_rsp [$];
   int      errors = 0;
   int      table_errors = 0;
   int      hold_req = 0;

   function automatic void fade(int s, inout logic [63:0] m);
      if (!fading[s]) m[s] = 1'b1;
      fading[s] = 1'b1;
   endfunction

   // computes the response of one event and updates the slot table
   function automatic rsp_type allocate(item_type it);
      rsp_type r;
      logic [1:0] k;
      bit cancel, found;
      int cand;
      r = '0;
      k = it.kind;
      if (k == KIND_NOTE_ON && it.velocity == 0) k = KIND_NOTE_OFF;
      case (k)
         KIND_NOTE_ON: begin
            cancel = (it.sample_status == SMP_EMPTY);
            if (!cancel)
               for (int s = 0; s < NSLOT; s++)
                  if (busy[s] && !fading[s] && s_voice[s] == it.voice_id
                      && s_note[s] == it.note_number) begin
                     if (s_rtg[s] == RTG_RESTART) fade(s, r.fade_mask);
                     else if (s_rtg[s] == RTG_NOTE_OFF) begin
                        fade(s, r.fade_mask);
                        cancel = 1;
                     end else if (s_rtg[s] == RTG_NONE) cancel = 1;
                     break;
                  end
            if (!cancel && it.choke_grp != 0)
               for (int s = 0; s < NSLOT; s++)
                  if (busy[s] && s_group[s] == it.choke_grp) fade(s, r.fade_mask);
            if (cancel) r.status = STAT_ABORTED;
            else begin
               found = 0;
               for (int s = 0; s < NSLOT; s++)
                  if (!busy[s]) begin
                     found = 1;
                     r.target_slot = 6'(s);
                     if (it.sample_status != SMP_NULL_LEN) begin
                        busy[s] = 1; fading[s] = 0; stolen[s] = 0;
                        s_voice[s] = it.voice_id; s_note[s] = it.note_number;
                        s_prio[s] = it.sample_priority; s_rtg[s] = it.retrig_sel;
                        s_group[s] = it.choke_grp; s_flags[s] = it.sample_flags;
                        s_pos[s] = 0;
                        r.start_volume = it.sample_flags[2] ? FULL_VOLUME : it.velocity;
                        r.status = STAT_STARTED;
                     end
                     break;
                  end
               if (!found) begin
                  cand = -1;
                  for (int s = 0; s < NSLOT; s++) begin
                     if (!busy[s] || stolen[s] || s_flags[s][0]) continue;
                     if (s_prio[s] > it.sample_priority) continue;
                     if (cand < 0 || s_prio[s] < s_prio[cand] ||
                         (s_prio[s] == s_prio[cand] && s_pos[s] > s_pos[cand]))
                        cand = s;
                  end
                  if (cand < 0) r.status = STAT_BLOCKED;
                  else begin
                     s_parked[cand] = {it.voice_id, it.note_number, it.velocity};
                     fade(cand, r.fade_mask);
                     stolen[cand] = 1;
                     r.status = STAT_STEAL;
                     r.target_slot = 6'(cand);
                  end
               end
            end
         end
         KIND_NOTE_OFF: begin
            for (int s = 0; s < NSLOT; s++)
               if (busy[s] && s_voice[s] == it.voice_id && s_note[s] == it.note_number
                   && s_flags[s][1])
                  fade(s, r.fade_mask);
         end
         KIND_PROGRESS: begin
            if (it.slot_index < NSLOT && busy[it.slot_index])
               s_pos[it.slot_index] = it.play_position;
         end
         default: begin
            if (it.slot_index < NSLOT && busy[it.slot_index]) begin
               busy[it.slot_index] = 0;
               fading[it.slot_index] = 0;
               s_pos[it.slot_index] = 0;
               r.target_slot = it.slot_index;
               if (stolen[it.slot_index]) begin
                  stolen[it.slot_index] = 0;
                  r.status = STAT_REQUEUE;
                  {r.out_voice, r.out_note, r.out_velocity} = s_parked[it.slot_index];
               end
            end
         end
      endcase
      return r;
   endfunction

   // checks a typed-in row against the predictor, restoring its busy, fading, stolen and position state
   function automatic bit allocate_peek_ok(item_type it, rsp_type e);
      rsp_type r;
      logic b [NSLOT], f [NSLOT], st [NSLOT];
      logic [31:0] p [NSLOT];
      b = busy; f = fading; st = stolen; p = s_pos;
      r = allocate(it);
      busy = b; fading = f; stolen = st; s_pos = p;
      if (r != e)
         $display("%0t table row %h exp %h got %h", $time, it, e, r);
      return r == e;
   endfunction

   // drives one beat and waits for its handshake; the predictor runs at accept
   task automatic send_event(item_type it);
      req_tvalid <= 1'b1;
      req_tuser  <= it.kind;
      req_tdata  <= {5'd0, it.sample_flags, it.choke_grp, it.retrig_sel,
                     it.sample_priority, it.sample_status, it.play_position,
                     it.slot_index, it.velocity, it.note_number, it.voice_id};
      do @(posedge clock); while (!req_tready);
      expected_rsp.push_back(allocate(it));
      @(negedge clock);
   endtask

   // sender gaps: bursts with no gap, then a random pause
   int burst_left = 0;
   task automatic sender_gap();
      if (burst_left > 0) burst_left--;
      else begin
         req_tvalid <= 1'b0;
         burst_left = $urandom_range(0, 12);
         repeat ($urandom_range(1, 30)) @(negedge clock);
      end
   endtask

   function automatic item_type random_event();
      item_type it;
      int r;
      it = ITEM_W'({$urandom, $urandom, $urandom});
      r = $urandom_range(0, 99);
      // narrow voice/note so retrigger and note-off matches happen
      if (r < 90) begin
         it.voice_id    = 8'($urandom_range(0, 3));
         it.note_number = 7'($urandom_range(60, 63));
         it.choke_grp   = 4'($urandom_range(0, 3));
         it.sample_status = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(1, 3)) : 2'd0;
         it.slot_index  = ($urandom_range(0, 19) == 0) ? 6'($urandom_range(0, 63))
                                                       : 6'($urandom_range(0, NSLOT - 1));
      end
      r = $urandom_range(0, 99);
      it.kind = (r < 45) ? KIND_NOTE_ON : (r < 60) ? KIND_NOTE_OFF :
                (r < 80) ? KIND_PROGRESS : KIND_FINISH;
      return it;
   endfunction

   function automatic item_type mk(logic [1:0] k, logic [7:0] v, logic [6:0] n,
                                   logic [6:0] vel, logic [5:0] si, logic [31:0] p,
                                   logic [1:0] ss, logic [3:0] pr, logic [1:0] rm,
                                   logic [3:0] g, logic [2:0] f);
      item_type it;
      it = {k, v, n, vel, si, p, ss, pr, rm, g, f};
      return it;
   endfunction

   item_type dir_item [$];
   bit       dir_has_exp [$];
   rsp_type  dir_exp [$];

   task automatic add_row(item_type it, bit has_exp = 0, rsp_type e = '0);
      dir_item.push_back(it);
      dir_has_exp.push_back(has_exp);
      dir_exp.push_back(e);
   endtask

   // receiver: its own stall pattern, plus one long hold that fills the queue
   initial begin
      int cnt;
      int hold_seen;
      hold_seen = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            rsp_tready <= 1'b0;
            for (cnt = 0; cnt < 300; cnt++) @(negedge clock);
         end
         case ($urandom_range(0, 3))
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 3) != 0);
            2: rsp_tready <= ($urandom_range(0, 1) != 0);
            default: rsp_tready <= ($urandom_range(0, 5) == 0);
         endcase
         @(negedge clock);
      end
   end

   // response checker
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_type got, e;
         got.status       = rsp_tuser;
         got.target_slot  = rsp_tdata[5:0];
         got.start_volume = rsp_tdata[12:6];
         got.fade_mask    = rsp_tdata[76:13];
         got.out_voice    = rsp_tdata[84:77];
         got.out_note     = rsp_tdata[91:85];
         got.out_velocity = rsp_tdata[98:92];
         if (expected_rsp.size() == 0) begin
            $display("%0t unexpected response %h", $time, got);
            errors++;
         end else begin
            e = expected_rsp.pop_front();
            if (got.status !== e.status) begin
               $display("%0t status exp %0d got %0d", $time, e.status, got.status);
               errors++;
            end
            if (got.target_slot !== e.target_slot) begin
               $display("%0t target_slot exp %0d got %0d", $time, e.target_slot,
                        got.target_slot);
               errors++;
            end
            if (got.start_volume !== e.start_volume) begin
               $display("%0t start_volume exp %0d got %0d", $time, e.start_volume,
                        got.start_volume);
               errors++;
            end
            if (got.fade_mask !== e.fade_mask) begin
               $display("%0t fade_mask exp %h got %h", $time, e.fade_mask, got.fade_mask);
               errors++;
            end
            if ({got.out_voice, got.out_note, got.out_velocity} !==
                {e.out_voice, e.out_note, e.out_velocity}) begin
               $display("%0t requeue note exp %h/%h/%h got %h/%h/%h", $time,
                        e.out_voice, e.out_note, e.out_velocity,
                        got.out_voice, got.out_note, got.out_velocity);
               errors++;
            end
         end
      end
   end

   initial begin
      #5_000_000;
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      rsp_type e;
      item_type it;
      int dcnt;
      for (int s = 0; s < NSLOT; s++) begin
         busy[s] = 0; fading[s] = 0; stolen[s] = 0; s_pos[s] = 0;
         s_voice[s] = 0; s_note[s] = 0; s_prio[s] = 0; s_rtg[s] = 0;
         s_group[s] = 0; s_flags[s] = 0; s_parked[s] = 0;
      end

      // directed table
      e = '0;
      add_row(mk(KIND_FINISH, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, e);        // finish on free
      add_row(mk(KIND_PROGRESS, 0, 0, 0, 63, '1, 0, 0, 0, 0, 0), 1, e);    // out of range
      e = '0; e.status = STAT_ABORTED;
      add_row(mk(KIND_NOTE_ON, 255, 127, 127, 0, 0, SMP_EMPTY, 0, 0, 0, 0), 1, e);
      e = '0; e.status = STAT_STARTED; e.start_volume = 127;
      add_row(mk(KIND_NOTE_ON, 255, 127, 1, 0, 0, 0, 15, 0, 0, 3'b110), 1, e);
      e = '0; e.target_slot = 6'd1;
      add_row(mk(KIND_NOTE_ON, 1, 1, 1, 0, 0, SMP_NULL_LEN, 0, 0, 0, 0), 1, e); // nothing, slot 1
      add_row(mk(KIND_NOTE_ON, 255, 127, 0, 0, 0, 0, 0, 0, 0, 0));            // velocity-0 off
      add_row(mk(KIND_FINISH, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      // fill with mixed priorities, retrigger modes and groups
      for (int s = 0; s < NSLOT; s++)
         add_row(mk(KIND_NOTE_ON, 8'(s % 4), 7'(60 + s % 4), 7'(10 + s), 0, 0, 2'd3,
                    4'(s % 5), 2'(s % 4), 4'(s % 3), 3'(s % 8)));
      add_row(mk(KIND_PROGRESS, 0, 0, 0, 5, 32'hFFFF_FFFF, 0, 0, 0, 0, 0));
      add_row(mk(KIND_NOTE_ON, 9, 9, 9, 0, 0, 0, 15, 0, 0, 0));   // steal
      add_row(mk(KIND_NOTE_ON, 9, 9, 9, 0, 0, 0, 0, 0, 0, 0));    // maybe blocked
      add_row(mk(KIND_NOTE_ON, 1, 61, 5, 0, 0, 0, 4, 0, 2, 0));   // retrigger + group
      for (int s = 0; s < NSLOT; s++)
         add_row(mk(KIND_FINISH, 0, 0, 0, 6'(s), 0, 0, 0, 0, 0, 0)); // requeues

      while (!(dir_item.size() == 0)) begin
         it = dir_item.pop_front();
         if (dir_has_exp.pop_front()) begin
            e = dir_exp.pop_front();
            if (allocate_peek_ok(it, e) == 0) table_errors++;
         end else void'(dir_exp.pop_front());
         if (dcnt == 0) begin
            repeat (2) @(negedge clock);
            reset <= 1'b0;
            dcnt = 1;
         end
         send_event(it);
         sender_gap();
      end

      // random part; one long receiver hold and one full drain pause
      for (int i = 0; i < N_RANDOM; i++) begin
         if (i == 100) hold_req = 1;
         if (i == 250) begin
            req_tvalid <= 1'b0;
            @(negedge clock);
            while (expected_rsp.size() != 0) @(negedge clock);
         end
         send_event(random_event());
         sender_gap();
      end

      req_tvalid <= 1'b0;
      while (expected_rsp.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (errors == 0 && table_errors == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule
